FILE: rtl/core/jdsl_pkg.sv
// Shared types and constants for the joystick drive slew limiter.
package jdsl_pkg;

  localparam logic [7:0]  DT_CLAMP_MS = 8'd200;
  localparam logic [16:0] AGE_MAX     = 17'h1FFFF;
  localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] S24_MIN = 24'sh800000;

  localparam logic FUNC_JOY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [3:0] {
    REG_STEER_MAG     = 4'd0,
    REG_MAX_FWD_SPEED = 4'd1,
    REG_MAX_REV_SPEED = 4'd2,
    REG_ACCEL_RATE    = 4'd3,
    REG_STEER_RATE    = 4'd4,
    REG_STEER_THRESH  = 4'd5,
    REG_STEER_DZ      = 4'd6,
    REG_JOY_TIMEOUT   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] steer_mag;
    logic [22:0]        max_forward_speed;
    logic [22:0]        max_reverse_speed;
    logic [15:0]        accel_rate;
    logic [15:0]        steer_rate;
    logic [15:0]        steer_threshold;
    logic [15:0]        steer_deadzone;
    logic [15:0]        joy_stale_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] speed;
    logic signed [23:0] steer;
  } target_t;

endpackage

FILE: rtl/core/jdsl_cfg_regs.sv
// Configuration register file with reset defaults.
module jdsl_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [3:0]        wr_index,
  input  logic [23:0]       wr_data,
  output jdsl_pkg::cfg_t    cfg
);

  jdsl_pkg::cfg_t cfg_r;
  jdsl_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        jdsl_pkg::REG_STEER_MAG:     cfg_nxt.steer_mag         = wr_data;
        jdsl_pkg::REG_MAX_FWD_SPEED: cfg_nxt.max_forward_speed = wr_data[22:0];
        jdsl_pkg::REG_MAX_REV_SPEED: cfg_nxt.max_reverse_speed = wr_data[22:0];
        jdsl_pkg::REG_ACCEL_RATE:    cfg_nxt.accel_rate        = wr_data[15:0];
        jdsl_pkg::REG_STEER_RATE:    cfg_nxt.steer_rate        = wr_data[15:0];
        jdsl_pkg::REG_STEER_THRESH:  cfg_nxt.steer_threshold   = wr_data[15:0];
        jdsl_pkg::REG_STEER_DZ:      cfg_nxt.steer_deadzone    = wr_data[15:0];
        jdsl_pkg::REG_JOY_TIMEOUT:   cfg_nxt.joy_stale_ms      = wr_data[15:0];
        default: ;  // indices past the map are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.steer_mag         <= -24'sd24000;
      cfg_r.max_forward_speed <= 23'd20000;
      cfg_r.max_reverse_speed <= 23'd10000;
      cfg_r.accel_rate        <= 16'd40;
      cfg_r.steer_rate        <= 16'd40;
      cfg_r.steer_threshold   <= 16'd19661;
      cfg_r.steer_deadzone    <= 16'd1638;
      cfg_r.joy_stale_ms      <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/jdsl_target.sv
// Steering and speed targets from the stored joystick state.
module jdsl_target (
  input  jdsl_pkg::cfg_t      cfg,
  input  logic                joy_seen,
  input  logic [16:0]         joy_age,
  input  logic signed [15:0]  axis,
  input  logic                fwd,
  input  logic                rev,
  output jdsl_pkg::target_t   tgt
);

  logic        fresh;
  logic [16:0] mag;
  logic        in_dz;
  logic        full;
  logic        pos;
  logic signed [24:0] neg_steer;
  logic signed [23:0] steer_t;

  always_comb begin
    fresh = joy_seen && (joy_age <= {1'b0, cfg.joy_stale_ms});
    mag   = axis[15] ? (17'd0 - {axis[15], axis}) : {1'b0, axis};
    in_dz = mag < {1'b0, cfg.steer_deadzone};
    // inside the deadzone the magnitude counts as zero
    full  = in_dz ? (cfg.steer_threshold == 16'd0)
                  : (mag >= {1'b0, cfg.steer_threshold});
    pos   = !in_dz && !axis[15] && (axis != 16'sd0);

    neg_steer = 25'sd0 - {cfg.steer_mag[23], cfg.steer_mag};
    if (cfg.steer_mag == jdsl_pkg::S24_MIN) begin
      steer_t = jdsl_pkg::S24_MAX;
    end else begin
      steer_t = neg_steer[23:0];
    end

    tgt.steer = 24'sd0;
    tgt.speed = 24'sd0;
    if (fresh) begin
      if (full) begin
        tgt.steer = pos ? cfg.steer_mag : steer_t;
      end
      if (fwd && !rev) begin
        tgt.speed = {1'b0, cfg.max_forward_speed};
      end else if (rev && !fwd) begin
        tgt.speed = 24'sd0 - {1'b0, cfg.max_reverse_speed};
      end
    end
  end

endmodule

FILE: rtl/core/jdsl_slew.sv
// One slew limiter: moves a command toward its target by at most rate * dt, or straight to it when jump is set.
module jdsl_slew (
  input  logic signed [23:0] cur,
  input  logic signed [23:0] target,
  input  logic [15:0]        rate,
  input  logic [7:0]         dt,
  input  logic               jump,
  output logic signed [23:0] nxt
);

  logic [23:0]        step;
  logic signed [25:0] d;
  logic signed [25:0] step_s;
  logic [24:0]        up;
  logic [24:0]        dn;

  always_comb begin
    step   = {8'd0, rate} * {16'd0, dt};
    d      = {{2{target[23]}}, target} - {{2{cur[23]}}, cur};
    step_s = {2'b00, step};
    // results stay between cur and target, so 24 bits always hold them
    up     = {cur[23], cur} + {1'b0, step};
    dn     = {cur[23], cur} - {1'b0, step};
    if (jump) begin
      nxt = target;
    end else if (d > step_s) begin
      nxt = up[23:0];
    end else if (d < -step_s) begin
      nxt = dn[23:0];
    end else begin
      nxt = target;
    end
  end

endmodule

FILE: rtl/core/joystick_drive_slew_limiter_core.sv
// A tick word's result is registered in the command registers after the word
// leaves the input register; a joystick update word yields no result.
// Throughput: one word per cycle unless a stalled result holds a tick word
// in the input register; the input register and the command registers form the two stages.
// Reset (synchronous, rst_n low): registers return to defaults, commands
// and joystick state clear, both channels empty.
module joystick_drive_slew_limiter_core (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic signed [15:0] in_steer_axis,
  input  logic               in_fwd_button,
  input  logic               in_rev_button,
  input  logic [15:0]        in_elapsed_ms,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_speed_out,
  output logic signed [23:0] out_steer_out,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  jdsl_pkg::cfg_t    cfg;
  jdsl_pkg::target_t tgt;

  // input register
  logic               s1_vld_r;
  logic               s1_func_r;
  logic signed [15:0] s1_axis_r;
  logic               s1_fwd_r;
  logic               s1_rev_r;
  logic [15:0]        s1_el_r;

  // block state; the command registers double as the result word
  logic               joy_seen_r;
  logic [16:0]        joy_age_r;
  logic signed [15:0] axis_r;
  logic               fwd_r;
  logic               rev_r;
  logic signed [23:0] speed_cmd_r;
  logic signed [23:0] steer_cmd_r;
  logic               out_vld_r;

  logic               out_free;
  logic               s1_go;
  logic               in_acc;
  logic               tick_go;
  logic               joy_go;
  logic [17:0]        age_sum;
  logic [16:0]        age_nxt;
  logic [7:0]         dt;
  logic signed [23:0] speed_nxt;
  logic signed [23:0] steer_nxt;

  assign cfg_ready = 1'b1;

  jdsl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_vld_r || !out_stall;
  assign s1_go    = s1_vld_r && ((s1_func_r == jdsl_pkg::FUNC_JOY) || out_free);
  assign in_stall = s1_vld_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;
  assign tick_go  = s1_go && (s1_func_r == jdsl_pkg::FUNC_TICK);
  assign joy_go   = s1_go && (s1_func_r == jdsl_pkg::FUNC_JOY);

  always_comb begin
    age_sum = {1'b0, joy_age_r} + {2'b00, s1_el_r};
    age_nxt = age_sum[17] ? jdsl_pkg::AGE_MAX : age_sum[16:0];
    dt      = (s1_el_r > {8'd0, jdsl_pkg::DT_CLAMP_MS}) ? jdsl_pkg::DT_CLAMP_MS
                                                       : s1_el_r[7:0];
  end

  jdsl_target u_target (
    .cfg      (cfg),
    .joy_seen (joy_seen_r),
    .joy_age  (age_nxt),
    .axis     (axis_r),
    .fwd      (fwd_r),
    .rev      (rev_r),
    .tgt      (tgt)
  );

  jdsl_slew u_speed_slew (
    .cur    (speed_cmd_r),
    .target (tgt.speed),
    .rate   (cfg.accel_rate),
    .dt     (dt),
    .jump   (1'b0),
    .nxt    (speed_nxt)
  );

  jdsl_slew u_steer_slew (
    .cur    (steer_cmd_r),
    .target (tgt.steer),
    .rate   (cfg.steer_rate),
    .dt     (dt),
    .jump   (cfg.steer_rate == 16'd0),
    .nxt    (steer_nxt)
  );

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_func;
      s1_axis_r <= in_steer_axis;
      s1_fwd_r  <= in_fwd_button;
      s1_rev_r  <= in_rev_button;
      s1_el_r   <= in_elapsed_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      joy_seen_r  <= 1'b0;
      joy_age_r   <= 17'd0;
      axis_r      <= 16'sd0;
      fwd_r       <= 1'b0;
      rev_r       <= 1'b0;
      speed_cmd_r <= 24'sd0;
      steer_cmd_r <= 24'sd0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end

      if (tick_go) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end

      if (joy_go) begin
        joy_seen_r <= 1'b1;
        joy_age_r  <= 17'd0;
        axis_r     <= s1_axis_r;
        fwd_r      <= s1_fwd_r;
        rev_r      <= s1_rev_r;
      end

      if (tick_go) begin
        joy_age_r   <= age_nxt;
        speed_cmd_r <= speed_nxt;
        steer_cmd_r <= steer_nxt;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_speed_out = speed_cmd_r;
  assign out_steer_out = steer_cmd_r;

endmodule
